// File: hw/rtl/tsa_pkg.sv
// tsa_pkg: shared widths, codes and arithmetic helpers of the truss stiffness assembly
// no dependencies; used by tsa_if.sv and truss_stiffness_assembly.sv
`default_nettype none

package tsa_pkg;

	localparam int NodeW      = 5;
	localparam int DofW       = 6;
	localparam int AddrW      = 2 * DofW;
	localparam int StoreDepth = 1 << AddrW;
	localparam int CoordW     = 32;
	localparam int EntryW     = 64;
	localparam int CfgW       = 6;
	localparam logic [CfgW-1:0] NodesReset = 6'd32;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EQUAL    = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_ZERO_LEN = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_CLEAR = 1'b1
	} command_t;

	// signed 64-bit add that clamps on overflow
	function automatic logic [EntryW-1:0] sat_add(input logic [EntryW-1:0] a,
			input logic [EntryW-1:0] b);
		logic [EntryW-1:0] s;
		s = a + b;
		if (a[EntryW-1] == b[EntryW-1] && s[EntryW-1] != a[EntryW-1]) begin
			sat_add = a[EntryW-1] ? {1'b1, {(EntryW-1){1'b0}}} : {1'b0, {(EntryW-1){1'b1}}};
		end else begin
			sat_add = s;
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tsa_if.sv
// tsa_if: request and result channel interfaces with valid/ready handshake
// depends on tsa_pkg for field widths
`default_nettype none

interface tsa_req_if;
	logic                               valid;
	logic                               ready;
	logic                               command;
	logic        [tsa_pkg::NodeW-1:0]   start_node;
	logic        [tsa_pkg::NodeW-1:0]   end_node;
	logic signed [tsa_pkg::CoordW-1:0]  start_x;
	logic signed [tsa_pkg::CoordW-1:0]  start_y;
	logic signed [tsa_pkg::CoordW-1:0]  end_x;
	logic signed [tsa_pkg::CoordW-1:0]  end_y;
	logic        [tsa_pkg::CoordW-1:0]  section_area;
	logic        [tsa_pkg::CoordW-1:0]  elastic_modulus;

	modport source(output valid, command, start_node, end_node, start_x, start_y, end_x, end_y,
		section_area, elastic_modulus, input ready);
	modport sink(input valid, command, start_node, end_node, start_x, start_y, end_x, end_y,
		section_area, elastic_modulus, output ready);
endinterface

interface tsa_rsp_if;
	logic                               valid;
	logic                               ready;
	logic        [tsa_pkg::DofW-1:0]    row_index;
	logic        [tsa_pkg::DofW-1:0]    col_index;
	logic signed [tsa_pkg::EntryW-1:0]  entry_value;
	logic        [1:0]                  status;
	logic                               last;

	modport source(output valid, row_index, col_index, entry_value, status, last, input ready);
	modport sink(input valid, row_index, col_index, entry_value, status, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/truss_stiffness_assembly.sv
// truss_stiffness_assembly: 2d truss bar assembly into a 64x64 global stiffness memory
// depends on tsa_pkg and the channel interfaces in tsa_if.sv
`default_nettype none

// channel   | dir | role
// ----------+-----+-------------------------------------------------
// req       | in  | add one bar, or clear the stiffness memory
// rsp       | out | updated entries (16 per bar) or one error result
// cfg_wen   | in  | write strobe for nodes_in_use (cfg_wdata)
//
// an add request runs, in order: squaring, square root, cosine and sine divides, multiplies,
//   stiffness divide, term multiplies, then 16 read/add/write updates, each a read step
//   and a write step
// the square root and the restoring divider (one bit per cycle) work serially
// an error request passes through S_ERR, which loads its single result once rsp is free
// clear and reset both zero all 4096 memory entries in a sweep; req.ready is low
// a stalled rsp holds the update loop in its write step; nothing is lost
module truss_stiffness_assembly (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [tsa_pkg::CfgW-1:0]  cfg_wdata,
	tsa_req_if.sink                        req,
	tsa_rsp_if.source                      rsp
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_CLR  = 12'b0000_0000_0010,
		S_ERR  = 12'b0000_0000_0100,
		S_SQ   = 12'b0000_0000_1000,
		S_SQRT = 12'b0000_0001_0000,
		S_DIVC = 12'b0000_0010_0000,
		S_DIVS = 12'b0000_0100_0000,
		S_MUL  = 12'b0000_1000_0000,
		S_DIVK = 12'b0001_0000_0000,
		S_TERM = 12'b0010_0000_0000,
		S_RD   = 12'b0100_0000_0000,
		S_WR   = 12'b1000_0000_0000
	} state_t;

	state_t                          state_q;
	logic [tsa_pkg::AddrW-1:0]       cnt_q;
	logic [tsa_pkg::CfgW-1:0]        nodes_q;

	// request fields held for the whole update
	logic [tsa_pkg::NodeW-1:0]       na_q, nb_q;
	logic [31:0]                     ax_q, ay_q, area_q, modulus_q;
	logic                            cs_neg_q;
	tsa_pkg::status_t                err_q;

	// shared 32x32 multiplier, product registered
	logic [31:0]                     mul_a, mul_b;
	logic [63:0]                     mul_p_q;
	logic [63:0]                     a2_q, ea_q, plo_q;

	// serial square root
	logic [65:0]                     sq_rad_q;
	logic [34:0]                     sq_rem_q;
	logic [32:0]                     sq_root_q;
	logic [36:0]                     sq_rem4, sq_trial, sq_rem_n;
	logic                            sq_ge;
	logic [32:0]                     sq_root_n;
	logic [32:0]                     len_q;

	// restoring divider by len_q
	logic [79:0]                     div_num_q;
	logic [32:0]                     div_rem_q;
	logic [63:0]                     div_quo_q;
	logic                            div_ovf_q;
	logic [33:0]                     div_rem2, div_diff;
	logic                            div_ge;
	logic [32:0]                     div_rem_n;
	logic [63:0]                     div_quo_n;
	logic                            div_ovf_n;

	logic [30:0]                     cm_q, sm_q;
	logic [30:0]                     mag_q [3];
	logic [62:0]                     k_q;
	logic [63:0]                     term_q [3];
	logic [1:0]                      t_idx;
	logic [30:0]                     t_mag;
	logic [95:0]                     t_sum;

	// stiffness memory
	logic [tsa_pkg::EntryW-1:0]      mem [tsa_pkg::StoreDepth];
	logic                            mem_we, mem_re;
	logic [tsa_pkg::AddrW-1:0]       mem_waddr, mem_raddr;
	logic [tsa_pkg::EntryW-1:0]      mem_wdata, mem_rdata_q;

	// update addressing
	logic [1:0]                      li, lj;
	logic [tsa_pkg::DofW-1:0]        row_w, col_w;
	logic [1:0]                      sel_w;
	logic                            neg_w;
	logic [63:0]                     term_sel, term_signed, sum_w;

	// request decode at accept
	logic                            accept;
	logic signed [32:0]              dx_w, dy_w;
	logic [32:0]                     ndx_w, ndy_w;
	logic [31:0]                     ax_w, ay_w;
	logic                            range_bad;

	// result register
	logic                            rsp_valid_q, rsp_last_q;
	logic [tsa_pkg::DofW-1:0]        rsp_row_q, rsp_col_q;
	logic [tsa_pkg::EntryW-1:0]      rsp_val_q;
	tsa_pkg::status_t                rsp_stat_q;
	logic                            out_free, load_err, load_ok;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign load_err  = (state_q == S_ERR) && out_free;
	assign load_ok   = (state_q == S_WR) && out_free;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.row_index   = rsp_row_q;
	assign rsp.col_index   = rsp_col_q;
	assign rsp.entry_value = rsp_val_q;
	assign rsp.status      = rsp_stat_q;
	assign rsp.last        = rsp_last_q;

	// exact 33-bit differences and their magnitudes
	assign dx_w  = {req.end_x[31], req.end_x} - {req.start_x[31], req.start_x};
	assign dy_w  = {req.end_y[31], req.end_y} - {req.start_y[31], req.start_y};
	assign ndx_w = ~dx_w + 33'd1;
	assign ndy_w = ~dy_w + 33'd1;
	assign ax_w  = dx_w[32] ? ndx_w[31:0] : dx_w[31:0];
	assign ay_w  = dy_w[32] ? ndy_w[31:0] : dy_w[31:0];
	assign range_bad = ({1'b0, req.start_node} >= nodes_q) || ({1'b0, req.end_node} >= nodes_q);

	// square root step: two radicand bits per cycle
	assign sq_rem4   = {sq_rem_q, sq_rad_q[65:64]};
	assign sq_trial  = {2'b00, sq_root_q, 2'b01};
	assign sq_ge     = (sq_rem4 >= sq_trial);
	assign sq_rem_n  = sq_ge ? (sq_rem4 - sq_trial) : sq_rem4;
	assign sq_root_n = {sq_root_q[31:0], sq_ge};

	// divider step: one quotient bit per cycle, overflow sticky past bit 63
	assign div_rem2  = {div_rem_q, div_num_q[79]};
	assign div_ge    = (div_rem2 >= {1'b0, len_q});
	assign div_diff  = div_rem2 - {1'b0, len_q};
	assign div_rem_n = div_ge ? div_diff[32:0] : div_rem2[32:0];
	assign div_quo_n = {div_quo_q[62:0], div_ge};
	assign div_ovf_n = div_ovf_q | div_quo_q[63];

	// term products: k split in a low and a high half against each pattern magnitude
	assign t_idx = cnt_q[2:1];
	always_comb begin
		case (t_idx)
			2'd1:    t_mag = mag_q[1];
			2'd2:    t_mag = mag_q[2];
			default: t_mag = mag_q[0];
		endcase
	end
	assign t_sum = {mul_p_q, 32'd0} + {32'd0, plo_q};

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			S_SQ: begin
				mul_a = (cnt_q == 12'd0) ? ax_q : ay_q;
				mul_b = (cnt_q == 12'd0) ? ax_q : ay_q;
			end
			S_MUL: begin
				case (cnt_q[2:0])
					3'd0: begin
						mul_a = modulus_q;
						mul_b = area_q;
					end
					3'd1: begin
						mul_a = {1'b0, cm_q};
						mul_b = {1'b0, cm_q};
					end
					3'd2: begin
						mul_a = {1'b0, cm_q};
						mul_b = {1'b0, sm_q};
					end
					3'd3: begin
						mul_a = {1'b0, sm_q};
						mul_b = {1'b0, sm_q};
					end
					default: begin
						mul_a = 32'd0;
						mul_b = 32'd0;
					end
				endcase
			end
			S_TERM: begin
				mul_a = cnt_q[0] ? {1'b0, k_q[62:32]} : k_q[31:0];
				mul_b = {1'b0, t_mag};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// local row li, column lj; rows 0,1 belong to the start node, 2,3 to the end node
	assign li    = cnt_q[3:2];
	assign lj    = cnt_q[1:0];
	assign row_w = {(li[1] ? nb_q : na_q), li[0]};
	assign col_w = {(lj[1] ? nb_q : na_q), lj[0]};
	assign sel_w = {1'b0, li[0]} + {1'b0, lj[0]};
	assign neg_w = ((sel_w == 2'd1) && cs_neg_q) != (li[1] != lj[1]);
	always_comb begin
		case (sel_w)
			2'd1:    term_sel = term_q[1];
			2'd2:    term_sel = term_q[2];
			default: term_sel = term_q[0];
		endcase
	end
	assign term_signed = neg_w ? (64'd0 - term_sel) : term_sel;
	assign sum_w       = tsa_pkg::sat_add(mem_rdata_q, term_signed);

	assign mem_we    = (state_q == S_CLR) || load_ok;
	assign mem_waddr = (state_q == S_CLR) ? cnt_q : {row_w, col_w};
	assign mem_wdata = (state_q == S_CLR) ? '0 : sum_w;
	assign mem_re    = (state_q == S_RD);
	assign mem_raddr = {row_w, col_w};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// control: sequencer, shared counter, register, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			nodes_q     <= tsa_pkg::NodesReset;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				nodes_q <= cfg_wdata;
			end
			if (load_err || load_ok) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.command == tsa_pkg::CMD_CLEAR) begin
							state_q <= S_CLR;
						end else if (req.start_node == req.end_node || range_bad
								|| (ax_w == 32'd0 && ay_w == 32'd0)) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q == 12'(tsa_pkg::StoreDepth - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SQ: begin
					if (cnt_q == 12'd2) begin
						cnt_q   <= 12'd33;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 12'd1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 12'd1) begin
						cnt_q   <= 12'd62;
						state_q <= S_DIVC;
					end else begin
						cnt_q <= cnt_q - 12'd1;
					end
				end
				S_DIVC: begin
					if (cnt_q == 12'd1) begin
						cnt_q   <= 12'd62;
						state_q <= S_DIVS;
					end else begin
						cnt_q <= cnt_q - 12'd1;
					end
				end
				S_DIVS: begin
					if (cnt_q == 12'd1) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q - 12'd1;
					end
				end
				S_MUL: begin
					if (cnt_q == 12'd4) begin
						cnt_q   <= 12'd80;
						state_q <= S_DIVK;
					end else begin
						cnt_q <= cnt_q + 12'd1;
					end
				end
				S_DIVK: begin
					if (cnt_q == 12'd1) begin
						cnt_q   <= '0;
						state_q <= S_TERM;
					end else begin
						cnt_q <= cnt_q - 12'd1;
					end
				end
				S_TERM: begin
					if (cnt_q == 12'd6) begin
						cnt_q   <= '0;
						state_q <= S_RD;
					end else begin
						cnt_q <= cnt_q + 12'd1;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						if (cnt_q[3:0] == 4'd15) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + 12'd1;
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (accept) begin
			na_q      <= req.start_node;
			nb_q      <= req.end_node;
			ax_q      <= ax_w;
			ay_q      <= ay_w;
			cs_neg_q  <= dx_w[32] != dy_w[32];
			area_q    <= req.section_area;
			modulus_q <= req.elastic_modulus;
			if (req.start_node == req.end_node) begin
				err_q <= tsa_pkg::STAT_EQUAL;
			end else if (range_bad) begin
				err_q <= tsa_pkg::STAT_RANGE;
			end else begin
				err_q <= tsa_pkg::STAT_ZERO_LEN;
			end
		end
		case (state_q)
			S_SQ: begin
				if (cnt_q == 12'd1) begin
					a2_q <= mul_p_q;
				end
				if (cnt_q == 12'd2) begin
					sq_rad_q  <= {1'b0, {1'b0, a2_q} + {1'b0, mul_p_q}};
					sq_rem_q  <= '0;
					sq_root_q <= '0;
				end
			end
			S_SQRT: begin
				sq_rad_q  <= {sq_rad_q[63:0], 2'b00};
				sq_rem_q  <= sq_rem_n[34:0];
				sq_root_q <= sq_root_n;
				if (cnt_q == 12'd1) begin
					len_q     <= sq_root_n;
					div_num_q <= {ax_q, 48'd0};
					div_rem_q <= '0;
					div_quo_q <= '0;
					div_ovf_q <= 1'b0;
				end
			end
			S_DIVC, S_DIVS, S_DIVK: begin
				if (cnt_q == 12'd1) begin
					// last quotient bit: take the result and rearm the divider
					div_rem_q <= '0;
					div_quo_q <= '0;
					div_ovf_q <= 1'b0;
					if (state_q == S_DIVC) begin
						cm_q      <= div_quo_n[30:0];
						div_num_q <= {ay_q, 48'd0};
					end else if (state_q == S_DIVS) begin
						sm_q <= div_quo_n[30:0];
					end else begin
						// stiffness at or above 2^63 clamps to the largest entry
						k_q <= (div_ovf_n || div_quo_n[63]) ? {63{1'b1}} : div_quo_n[62:0];
					end
				end else begin
					div_num_q <= {div_num_q[78:0], 1'b0};
					div_rem_q <= div_rem_n;
					div_quo_q <= div_quo_n;
					div_ovf_q <= div_ovf_n;
				end
			end
			S_MUL: begin
				case (cnt_q[2:0])
					3'd1: ea_q <= mul_p_q;
					3'd2: mag_q[0] <= mul_p_q[60:30];
					3'd3: mag_q[1] <= mul_p_q[60:30];
					3'd4: begin
						mag_q[2]  <= mul_p_q[60:30];
						div_num_q <= {ea_q, 16'd0};
						div_rem_q <= '0;
						div_quo_q <= '0;
						div_ovf_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			S_TERM: begin
				// odd step: low half done; even step after 0: high half done, fold
				if (cnt_q[0]) begin
					plo_q <= mul_p_q;
				end else if (cnt_q[2:0] != 3'd0) begin
					term_q[t_idx - 2'd1] <= t_sum[93:30];
				end
			end
			default: begin
			end
		endcase
		if (load_err) begin
			rsp_row_q  <= '0;
			rsp_col_q  <= '0;
			rsp_val_q  <= '0;
			rsp_stat_q <= err_q;
			rsp_last_q <= 1'b1;
		end else if (load_ok) begin
			rsp_row_q  <= row_w;
			rsp_col_q  <= col_w;
			rsp_val_q  <= sum_w;
			rsp_stat_q <= tsa_pkg::STAT_OK;
			rsp_last_q <= (cnt_q[3:0] == 4'd15);
		end
	end

	// an error result is always the only and final one
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != tsa_pkg::STAT_OK |-> rsp.last)
		else $error("error result without last");

	// a new request never lands while an update sequence still has results to give
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !(rsp_valid_q && !rsp_last_q))
		else $error("request taken mid sequence");

	// each written-back entry appears on the result port with its address and value
	a_wb_match: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == S_WR |=> rsp.valid
		&& {rsp.row_index, rsp.col_index} == $past(mem_waddr)
		&& rsp.entry_value == $past(mem_wdata))
		else $error("result does not match write-back");

endmodule

`default_nettype wire

// File: test/tb_truss_stiffness_assembly.sv
// testbench for truss_stiffness_assembly: directed bars, error cases, node limits, stalls
// and random bars; a local stiffness mirror predicts every entry; needs tsa_pkg and tsa_if
`timescale 1ns / 100ps

module tb_truss_stiffness_assembly;

	typedef struct {
		tsa_pkg::command_t                  cmd;
		logic [tsa_pkg::NodeW-1:0]          sn;
		logic [tsa_pkg::NodeW-1:0]          en;
		logic signed [31:0]                 sx;
		logic signed [31:0]                 sy;
		logic signed [31:0]                 ex;
		logic signed [31:0]                 ey;
		logic [31:0]                        area;
		logic [31:0]                        modulus;
	} bar_req_t;

	typedef struct {
		logic [tsa_pkg::DofW-1:0]   row;
		logic [tsa_pkg::DofW-1:0]   col;
		logic [tsa_pkg::EntryW-1:0] value;
		tsa_pkg::status_t           status;
		logic                       last;
	} entry_t;

	localparam logic [63:0] EntryMax = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] EntryMin = 64'h8000_0000_0000_0000;
	localparam int          DrainGap = 4200;   // covers a clear sweep, which gives no result

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wen = 1'b0;
	logic [tsa_pkg::CfgW-1:0]   cfg_wdata = '0;

	tsa_req_if req ();
	tsa_rsp_if rsp ();

	truss_stiffness_assembly u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// stiffness mirror and the entries still owed by the block
	logic [tsa_pkg::EntryW-1:0] stiffness_mirror [0:tsa_pkg::StoreDepth-1];
	logic [tsa_pkg::CfgW-1:0]   nodes_mirror = tsa_pkg::NodesReset;
	entry_t                     pending_entries [$];
	int                         mismatches = 0;
	int                         tx_idle_pct = 0;
	int                         rx_idle_pct = 0;
	int                         rx_hold_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? EntryMin : EntryMax;
		end
		return s;
	endfunction

	function automatic logic [63:0] root_floor(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= n) begin
				r = t;
			end
		end
		return r;
	endfunction

	function automatic void push_error(input tsa_pkg::status_t code);
		entry_t e;
		e.row = '0;
		e.col = '0;
		e.value = '0;
		e.status = code;
		e.last = 1'b1;
		pending_entries.insert(pending_entries.size(), e);
	endfunction

	// predict one accepted request: update the mirror and queue its entries
	function automatic void assemble_bar(input bar_req_t b);
		longint      dx;
		longint      dy;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] len;
		logic [63:0] cm;
		logic [63:0] sm;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] k;
		logic [63:0] term;
		logic [63:0] mag [3];
		logic        neg [3];
		logic [127:0] prod;
		int          dof [4];
		int          sel;
		int          addr;
		logic        negative;
		entry_t      e;
		if (b.cmd == tsa_pkg::CMD_CLEAR) begin
			foreach (stiffness_mirror[i]) stiffness_mirror[i] = '0;
			return;
		end
		if (b.sn == b.en) begin
			push_error(tsa_pkg::STAT_EQUAL);
			return;
		end
		if (b.sn >= nodes_mirror || b.en >= nodes_mirror) begin
			push_error(tsa_pkg::STAT_RANGE);
			return;
		end
		dx = longint'(b.ex) - longint'(b.sx);
		dy = longint'(b.ey) - longint'(b.sy);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		len = root_floor({64'd0, ax * ax} + {64'd0, ay * ay});
		if (len == 0) begin
			push_error(tsa_pkg::STAT_ZERO_LEN);
			return;
		end
		cm = (ax << 30) / len;
		sm = (ay << 30) / len;
		mag[0] = (cm * cm) >> 30; neg[0] = 1'b0;
		mag[1] = (cm * sm) >> 30; neg[1] = (dx < 0) != (dy < 0);
		mag[2] = (sm * sm) >> 30; neg[2] = 1'b0;
		p = {32'd0, b.area} * {32'd0, b.modulus};
		q = p / len;
		if (q >= (64'd1 << 47)) begin
			k = EntryMax;
		end else begin
			k = (q << 16) + (((p % len) << 16) / len);
		end
		dof[0] = 2 * b.sn;
		dof[1] = 2 * b.sn + 1;
		dof[2] = 2 * b.en;
		dof[3] = 2 * b.en + 1;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				sel = (i & 1) + (j & 1);
				negative = neg[sel] != ((i < 2) != (j < 2));
				prod = {64'd0, k} * {64'd0, mag[sel]};
				term = prod[93:30];
				if (negative) begin
					term = -term;
				end
				addr = dof[i] * 64 + dof[j];
				stiffness_mirror[addr] = clamp_add(stiffness_mirror[addr], term);
				e.row = dof[i][tsa_pkg::DofW-1:0];
				e.col = dof[j][tsa_pkg::DofW-1:0];
				e.value = stiffness_mirror[addr];
				e.status = tsa_pkg::STAT_OK;
				e.last = (i == 3 && j == 3);
				pending_entries.insert(pending_entries.size(), e);
			end
		end
	endfunction

	// result side: ready changes at the falling edge, with an optional long hold-off
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rsp.ready = 1'b0;
			rx_hold_left--;
		end else begin
			rsp.ready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		entry_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected result row %0d col %0d", rsp.row_index, rsp.col_index);
				mismatches++;
			end else begin
				e = pending_entries.pop_front();
				if (rsp.row_index !== e.row) begin
					$error("row_index expected %0d got %0d", e.row, rsp.row_index);
					mismatches++;
				end
				if (rsp.col_index !== e.col) begin
					$error("col_index expected %0d got %0d", e.col, rsp.col_index);
					mismatches++;
				end
				if (rsp.entry_value !== e.value) begin
					$error("entry_value expected %h got %h", e.value, rsp.entry_value);
					mismatches++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, rsp.status);
					mismatches++;
				end
				if (rsp.last !== e.last) begin
					$error("last expected %0d got %0d", e.last, rsp.last);
					mismatches++;
				end
			end
		end
	end

	function automatic bar_req_t make_bar(input int sn, input int en, input int sx,
			input int sy, input int ex, input int ey, input int unsigned area,
			input int unsigned modulus);
		bar_req_t b;
		b.cmd = tsa_pkg::CMD_ADD;
		b.sn = sn[tsa_pkg::NodeW-1:0];
		b.en = en[tsa_pkg::NodeW-1:0];
		b.sx = sx;
		b.sy = sy;
		b.ex = ex;
		b.ey = ey;
		b.area = area;
		b.modulus = modulus;
		return b;
	endfunction

	function automatic bar_req_t make_clear();
		bar_req_t b;
		b = make_bar($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		b.cmd = tsa_pkg::CMD_CLEAR;
		return b;
	endfunction

	// send one request; entered and left at a falling edge, valid stays high on return
	task automatic send_bar(input bar_req_t b);
		if ($urandom_range(99) < tx_idle_pct) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.command = b.cmd;
		req.start_node = b.sn;
		req.end_node = b.en;
		req.start_x = b.sx;
		req.start_y = b.sy;
		req.end_x = b.ex;
		req.end_y = b.ey;
		req.section_area = b.area;
		req.elastic_modulus = b.modulus;
		req.valid = 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		assemble_bar(b);
		@(negedge clk);
	endtask

	// sender pauses until every owed entry has come back
	task automatic wait_drain();
		req.valid = 1'b0;
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_node_count(input logic [tsa_pkg::CfgW-1:0] value);
		wait_drain();
		repeat (DrainGap) @(negedge clk);
		cfg_wen = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
		nodes_mirror = value;
	endtask

	// axis-aligned, diagonal and extreme bars, saturation of entries and a clear
	task automatic test_directed_bars();
		send_bar(make_bar(0, 1, 0, 0, 32'h0002_0000, 0, 32'h0001_0000, 1000));
		send_bar(make_bar(1, 2, 0, 0, 0, 32'h0003_0000, 32'h0000_8000, 200));
		send_bar(make_bar(2, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0002_0000, 77));
		send_bar(make_bar(3, 4, 0, 0, -32'sh0004_0000, 32'h0003_0000, 32'h0001_8000, 12345));
		send_bar(make_bar(31, 30, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_bar(0, 31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			0, 32'hFFFF_FFFF));
		send_bar(make_bar(5, 6, 0, 0, 1, 0, 32'hFFFF_FFFF, 0));
		// tiny horizontal bar with huge stiffness, twice, to clamp both ways
		send_bar(make_bar(7, 8, 0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_bar(7, 8, 0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_bar(9, 10, 0, 0, 0, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_bar(9, 10, 0, 0, 0, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_clear());
		send_bar(make_bar(7, 8, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 50));
		wait_drain();
	endtask

	// equal nodes and zero length, none of which touches the store, then one valid bar
	task automatic test_error_cases();
		send_bar(make_bar(4, 4, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 10));
		send_bar(make_bar(31, 31, 0, 0, 0, 0, 0, 0));
		send_bar(make_bar(11, 12, 32'h1234_5678, -32'sh0000_0042, 32'h1234_5678,
			-32'sh0000_0042, 32'h0001_0000, 10));
		send_bar(make_bar(12, 11, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_bar(make_bar(11, 12, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 10));
		wait_drain();
	endtask

	// node limit at its extremes: none, one, a few and beyond the store
	task automatic test_node_limits();
		write_node_count(6'd5);
		send_bar(make_bar(4, 3, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 9));
		send_bar(make_bar(5, 3, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		send_bar(make_bar(0, 17, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		write_node_count(6'd0);
		send_bar(make_bar(0, 1, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		write_node_count(6'd1);
		send_bar(make_bar(0, 1, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		send_bar(make_bar(0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		write_node_count(6'd63);
		send_bar(make_bar(31, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 9));
		write_node_count(6'd32);
	endtask

	function automatic int rand_coord();
		if ($urandom_range(1)) begin
			return $urandom;
		end
		return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
	endfunction

	function automatic bar_req_t random_bar();
		bar_req_t    b;
		int unsigned limit;
		int unsigned pick;
		int unsigned sn_pick;
		int unsigned en_pick;
		limit = (nodes_mirror > 32) ? 32 : nodes_mirror;
		pick = $urandom_range(99);
		if (pick < 2) begin
			return make_clear();
		end
		b = make_bar($urandom_range(31), $urandom_range(31), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(),
			$urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000),
			$urandom_range(1) ? $urandom : $urandom_range(100000));
		// mostly well-formed bars within the node limit, a few broken ones
		if (pick >= 12 && limit >= 2) begin
			sn_pick = $urandom_range(limit - 1);
			b.sn = sn_pick[tsa_pkg::NodeW-1:0];
			do begin
				en_pick = $urandom_range(limit - 1);
				b.en = en_pick[tsa_pkg::NodeW-1:0];
			end while (b.en == b.sn);
		end else if (pick < 6) begin
			b.en = b.sn;
		end
		if (pick >= 6 && pick < 9) begin
			b.ex = b.sx;
			b.ey = b.sy;
		end
		return b;
	endfunction

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_bar(random_bar());
		end
		wait_drain();
	endtask

	// result side holds off long enough that the block fills and stalls its input
	task automatic test_backpressure();
		rx_hold_left = 1500;
		for (int n = 0; n < 12; n++) begin
			send_bar(make_bar(n, n + 1, rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), $urandom, $urandom_range(5000)));
		end
		wait_drain();
	endtask

	initial begin
		req.valid = 1'b0;
		req.command = tsa_pkg::CMD_ADD;
		req.start_node = '0;
		req.end_node = '0;
		req.start_x = '0;
		req.start_y = '0;
		req.end_x = '0;
		req.end_y = '0;
		req.section_area = '0;
		req.elastic_modulus = '0;
		rsp.ready = 1'b0;
		foreach (stiffness_mirror[i]) stiffness_mirror[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 14;
		rx_idle_pct = 67;
		test_directed_bars();
		test_error_cases();
		test_node_limits();
		test_random(100);
		test_backpressure();

		tx_idle_pct = 67;
		rx_idle_pct = 14;
		write_node_count(6'd63);
		test_random(100);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_node_count(6'd7);
		test_random(100);

		wait_drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_entries.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/tsa_pkg.sv
hw/rtl/tsa_if.sv
hw/rtl/truss_stiffness_assembly.sv
test/tb_truss_stiffness_assembly.sv
